>>> sv/filled_circle_span_generator_core_macros.svh
// Assertion helpers for the checker file.
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_CORE_MACROS_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define FCSG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcsg check failed");

// Next-cycle implication, held off during reset.
`define FCSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcsg check failed");

`endif

>>> sv/fcsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcsg_pkg;

	localparam int RADIUS_W = 5;
	localparam int COLOR_W  = 16;
	localparam int CFG_W    = 11;
	localparam int LEN_W    = RADIUS_W + 1;

	localparam logic [CFG_W-1:0] DISPLAY_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] DISPLAY_HEIGHT_RST = 11'd480;

	// register indexes on the configuration port
	localparam logic REG_DISPLAY_WIDTH  = 1'b0;
	localparam logic REG_DISPLAY_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CENTER,
		ST_TEST_A,
		ST_TEST_B,
		ST_OUT_P,
		ST_OUT_M,
		ST_IN_P,
		ST_IN_M,
		ST_FLUSH
	} fcsg_state_t;

	// last step index: floor(r * 0.707) + 1
	function automatic logic [RADIUS_W-1:0] step_limit_lut(input logic [RADIUS_W-1:0] r);
		logic [RADIUS_W-1:0] v;
		case (r)
			5'd0:    v = 5'd1;
			5'd1:    v = 5'd1;
			5'd2:    v = 5'd2;
			5'd3:    v = 5'd3;
			5'd4:    v = 5'd3;
			5'd5:    v = 5'd4;
			5'd6:    v = 5'd5;
			5'd7:    v = 5'd5;
			5'd8:    v = 5'd6;
			5'd9:    v = 5'd7;
			5'd10:   v = 5'd8;
			5'd11:   v = 5'd8;
			5'd12:   v = 5'd9;
			5'd13:   v = 5'd10;
			5'd14:   v = 5'd10;
			5'd15:   v = 5'd11;
			5'd16:   v = 5'd12;
			5'd17:   v = 5'd13;
			5'd18:   v = 5'd13;
			5'd19:   v = 5'd14;
			5'd20:   v = 5'd15;
			5'd21:   v = 5'd15;
			5'd22:   v = 5'd16;
			5'd23:   v = 5'd17;
			5'd24:   v = 5'd17;
			5'd25:   v = 5'd18;
			5'd26:   v = 5'd19;
			5'd27:   v = 5'd20;
			5'd28:   v = 5'd20;
			5'd29:   v = 5'd21;
			5'd30:   v = 5'd22;
			default: v = 5'd22;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> sv/filled_circle_span_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The first span word is offered once a later span or the flush pushes the center span on.
// Circles are handled one at a time: the single squarer/compare sequence and the one span
//   slot per cycle (which waits while a full output register is held) serve one circle.
//   s_axis_tready is high only between circles.
// Reset (arst_n low, asynchronous): sequencer idle, no word pending, display 640 x 480.
module filled_circle_span_generator_core #(
	parameter int MAX_RADIUS = 19,
	parameter int COORD_BITS = 10
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// center_x, center_y, radius, fill_color (lowest bits first), zero padded
	input  wire [((2*COORD_BITS+21+7)/8)*8-1:0]    s_axis_tdata,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// span_row, span_x_first, span_x_last, span_color (lowest bits first), zero padded
	output logic [((3*COORD_BITS+16+7)/8)*8-1:0]   m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// last_span: final span of the circle
	output logic                                  m_axis_tlast,
	input  wire                                   cfg_wr_en,
	input  wire                                   cfg_index,
	input  wire [fcsg_pkg::CFG_W-1:0]              cfg_data
);

	localparam int RW   = fcsg_pkg::RADIUS_W;
	localparam int CW   = fcsg_pkg::COLOR_W;
	localparam int LW   = fcsg_pkg::LEN_W;
	localparam int SW   = COORD_BITS + 2;               // signed coordinate width
	localparam int ZW   = (COORD_BITS + 1 > fcsg_pkg::CFG_W) ? COORD_BITS + 1 : fcsg_pkg::CFG_W;
	localparam int OUTW = 3*COORD_BITS + CW;
	localparam int OTW  = ((OUTW + 7) / 8) * 8;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [fcsg_pkg::CFG_W-1:0] disp_w_q, disp_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_w_q <= fcsg_pkg::DISPLAY_WIDTH_RST;
			disp_h_q <= fcsg_pkg::DISPLAY_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fcsg_pkg::REG_DISPLAY_WIDTH:  disp_w_q <= cfg_data;
				fcsg_pkg::REG_DISPLAY_HEIGHT: disp_h_q <= cfg_data;
			endcase
		end
	end

	// Largest legal coordinate for a display size: zero acts as one, and a
	// size above the coordinate range saturates to it.
	function automatic logic [COORD_BITS-1:0] size_lim(input logic [fcsg_pkg::CFG_W-1:0] sz);
		logic [ZW-1:0] ext;
		logic [ZW-1:0] top;
		logic [COORD_BITS-1:0] r;
		ext = ZW'(sz);
		top = ZW'(1) << COORD_BITS;
		if (ext == '0)
			r = '0;
		else if (ext > top)
			r = COORD_BITS'(top - ZW'(1));
		else
			r = COORD_BITS'(ext - ZW'(1));
		return r;
	endfunction

	// Clamp a signed coordinate into 0 .. lim.
	function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
	                                                 input logic [COORD_BITS-1:0] lim);
		logic [COORD_BITS-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed({2'b00, lim}))
			r = lim;
		else
			r = v[COORD_BITS-1:0];
		return r;
	endfunction

	logic [COORD_BITS-1:0] wlim, hlim;
	assign wlim = size_lim(disp_w_q);
	assign hlim = size_lim(disp_h_q);

	// ---------------------------------------------------------------------
	// Input word unpacking
	// ---------------------------------------------------------------------
	logic [COORD_BITS-1:0] in_cx, in_cy;
	logic [RW-1:0]         in_r, in_r_sat;
	logic [CW-1:0]         in_color;

	assign in_cx    = s_axis_tdata[COORD_BITS-1:0];
	assign in_cy    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_r     = s_axis_tdata[2*COORD_BITS+RW-1:2*COORD_BITS];
	assign in_color = s_axis_tdata[2*COORD_BITS+RW+CW-1:2*COORD_BITS+RW];
	assign in_r_sat = (in_r > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : in_r;

	// ---------------------------------------------------------------------
	// Sequencer state and per-circle registers
	// ---------------------------------------------------------------------
	fcsg_pkg::fcsg_state_t state_q, state_d;

	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic [CW-1:0]         color_q;
	logic [RW-1:0]         i_q, x_q, imax_q;
	logic [8:0]            bound_q;
	logic [2*RW-1:0]       acc_q;

	// Pending span: held back one slot so the final one can be marked.
	logic                  pend_vld_q;
	logic [COORD_BITS-1:0] pend_row_q, pend_xf_q, pend_xl_q;

	// Output register
	logic                  out_vld_q, out_last_q;
	logic [COORD_BITS-1:0] out_row_q, out_xf_q, out_xl_q;
	logic [CW-1:0]         out_color_q;

	// ---------------------------------------------------------------------
	// Shared squarer: bound in SETUP, i*i in TEST_A, x*x in TEST_B
	// ---------------------------------------------------------------------
	logic [RW-1:0]   sq_in;
	logic [2*RW-1:0] sq_out;
	logic            hit;

	assign sq_out = sq_in * sq_in;
	assign hit    = ({1'b0, acc_q} + {1'b0, sq_out}) > (2*RW+1)'(bound_q);

	// ---------------------------------------------------------------------
	// Shared span unit: one candidate span per emitting state
	// ---------------------------------------------------------------------
	logic                  emit_st;
	logic [RW-1:0]         cand_xoff;   // subtracted from center column
	logic                  cand_plus1;  // outer spans start one column right
	logic                  cand_down;   // row above (minus) or below (plus) center
	logic [RW-1:0]         cand_yoff;
	logic [LW-1:0]         cand_len;
	logic signed [SW-1:0]  cand_sx, cand_ex, cand_row;
	logic [COORD_BITS-1:0] cand_row_c, cand_xf_c, cand_xl_c;
	logic                  cand_ok, out_free, adv, cand_fire, push;
	logic [RW-1:0]         x_dec;

	assign x_dec = (x_q != '0) ? x_q - RW'(1) : x_q;

	always_comb begin
		emit_st    = 1'b0;
		cand_xoff  = x_q;
		cand_plus1 = 1'b0;
		cand_down  = 1'b0;
		cand_yoff  = '0;
		cand_len   = {x_q, 1'b0};
		sq_in      = i_q;
		unique case (state_q)
			fcsg_pkg::ST_SETUP:  sq_in = x_q;
			fcsg_pkg::ST_TEST_B: sq_in = x_q;
			fcsg_pkg::ST_CENTER: begin
				emit_st = 1'b1;
			end
			fcsg_pkg::ST_OUT_P, fcsg_pkg::ST_OUT_M: begin
				emit_st    = 1'b1;
				cand_xoff  = i_q;
				cand_plus1 = 1'b1;
				cand_yoff  = x_q;
				cand_down  = (state_q == fcsg_pkg::ST_OUT_M);
				cand_len   = {i_q - RW'(1), 1'b0};
			end
			fcsg_pkg::ST_IN_P, fcsg_pkg::ST_IN_M: begin
				emit_st   = 1'b1;
				cand_yoff = i_q;
				cand_down = (state_q == fcsg_pkg::ST_IN_M);
			end
			default: ;
		endcase
	end

	always_comb begin
		cand_sx  = $signed({2'b00, cx_q}) - $signed(SW'(cand_xoff))
		         + $signed(SW'(cand_plus1));
		cand_ex  = cand_sx + $signed(SW'(cand_len)) - $signed(SW'(1));
		cand_row = cand_down ? $signed({2'b00, cy_q}) - $signed(SW'(cand_yoff))
		                     : $signed({2'b00, cy_q}) + $signed(SW'(cand_yoff));
	end

	assign cand_row_c = clamp(cand_row, hlim);
	assign cand_xf_c  = clamp(cand_sx, wlim);
	assign cand_xl_c  = clamp(cand_ex, wlim);

	assign cand_ok   = emit_st && (cand_len != '0);
	assign out_free  = !out_vld_q || m_axis_tready;
	// Stall only when a real span must push the pending one into a full output.
	assign adv       = !cand_ok || !pend_vld_q || out_free;
	assign cand_fire = cand_ok && adv;
	assign push      = (cand_fire && pend_vld_q) ||
	                   ((state_q == fcsg_pkg::ST_FLUSH) && out_free);

	// ---------------------------------------------------------------------
	// Next state
	// ---------------------------------------------------------------------
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			fcsg_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (in_r_sat != '0))
					state_d = fcsg_pkg::ST_SETUP;
			end
			fcsg_pkg::ST_SETUP:  state_d = fcsg_pkg::ST_CENTER;
			fcsg_pkg::ST_CENTER: if (adv) state_d = fcsg_pkg::ST_TEST_A;
			fcsg_pkg::ST_TEST_A: state_d = fcsg_pkg::ST_TEST_B;
			fcsg_pkg::ST_TEST_B: begin
				if (hit && (x_q > imax_q))
					state_d = fcsg_pkg::ST_OUT_P;
				else
					state_d = fcsg_pkg::ST_IN_P;
			end
			fcsg_pkg::ST_OUT_P: if (adv) state_d = fcsg_pkg::ST_OUT_M;
			fcsg_pkg::ST_OUT_M: if (adv) state_d = fcsg_pkg::ST_IN_P;
			fcsg_pkg::ST_IN_P:  if (adv) state_d = fcsg_pkg::ST_IN_M;
			fcsg_pkg::ST_IN_M: begin
				if (adv)
					state_d = (i_q == imax_q) ? fcsg_pkg::ST_FLUSH : fcsg_pkg::ST_TEST_A;
			end
			fcsg_pkg::ST_FLUSH: if (out_free) state_d = fcsg_pkg::ST_IDLE;
			default: state_d = fcsg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fcsg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------------------------------------------------------------
	// Step counters and edge offset
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			x_q        <= '0;
			imax_q     <= '0;
			bound_q    <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				fcsg_pkg::ST_IDLE: begin
					if (s_axis_tvalid) begin
						x_q <= in_r_sat;
						i_q <= RW'(1);
					end
				end
				fcsg_pkg::ST_SETUP: begin
					bound_q <= 9'(sq_out + (2*RW)'(x_q >> 1));
					imax_q  <= fcsg_pkg::step_limit_lut(x_q);
				end
				fcsg_pkg::ST_TEST_B: begin
					// drop x now unless the outer rows still need it
					if (hit && !(x_q > imax_q))
						x_q <= x_dec;
				end
				fcsg_pkg::ST_OUT_M: if (adv) x_q <= x_dec;
				fcsg_pkg::ST_IN_M: begin
					if (adv && (i_q != imax_q))
						i_q <= i_q + RW'(1);
				end
				default: ;
			endcase

			if (cand_fire)
				pend_vld_q <= 1'b1;
			else if ((state_q == fcsg_pkg::ST_FLUSH) && out_free)
				pend_vld_q <= 1'b0;

			if (push)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cx_q    <= in_cx;
			cy_q    <= in_cy;
			color_q <= in_color;
		end
		if (state_q == fcsg_pkg::ST_TEST_A)
			acc_q <= sq_out;
		if (cand_fire) begin
			pend_row_q <= cand_row_c;
			pend_xf_q  <= cand_xf_c;
			pend_xl_q  <= cand_xl_c;
		end
		if (push) begin
			out_row_q   <= pend_row_q;
			out_xf_q    <= pend_xf_q;
			out_xl_q    <= pend_xl_q;
			out_color_q <= color_q;
			out_last_q  <= (state_q == fcsg_pkg::ST_FLUSH);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OTW'({out_color_q, out_xl_q, out_xf_q, out_row_q});

endmodule

`default_nettype wire

>>> sv/fcsg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "filled_circle_span_generator_core_macros.svh"

module fcsg_checker #(
	parameter int COORD_BITS = 10
) (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  s_axis_tvalid,
	input wire                                  s_axis_tready,
	input wire [((3*COORD_BITS+16+7)/8)*8-1:0]   m_axis_tdata,
	input wire                                  m_axis_tvalid,
	input wire                                  m_axis_tready,
	input wire                                  m_axis_tlast
);

	logic [COORD_BITS-1:0] xf, xl;
	logic                  in_word;
	logic                  out_stall;

	assign xf        = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign xl        = m_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign in_word   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`FCSG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid)
	`FCSG_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable({m_axis_tdata, m_axis_tlast}))
	// a new circle is only taken once every span but the final one has drained
	`FCSG_ASSERT_IMPL(a_ready_after_last, clk, arst_n, s_axis_tready && m_axis_tvalid, m_axis_tlast)
	`FCSG_ASSERT_IMPL(a_span_order, clk, arst_n, m_axis_tvalid, xf <= xl)
	// no span of a new circle shows up in the cycle right after it was taken
	`FCSG_ASSERT_NEXT(a_no_span_after_take, clk, arst_n, in_word, !m_axis_tvalid || m_axis_tlast)

endmodule

bind filled_circle_span_generator_core fcsg_checker #(.COORD_BITS(COORD_BITS)) u_fcsg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> dv/tb_filled_circle_span_generator_core.sv
`timescale 1ns / 1ps
// Filled circle span generator, stream-level check.
// Circle words go in on the slave side; every span word that comes back is
// compared field by field against a span list computed here from the same
// circle and the display size in force. A short directed set covers the
// display corners, clipping below zero and beyond the display, the zero and
// oversized radius and the zero and oversized display. Random circles
// follow in three rounds with different idle patterns on the two sides.
module tb_filled_circle_span_generator_core;

	localparam int CLK_PERIOD  = 20;
	localparam int CYCLE_LIMIT = 2_000_000;
	// Settling room after draining, so a zero-radius request that yields no span can finish.
	localparam int SETTLE      = 100;
	localparam int TOP_RADIUS  = 19;
	localparam int CFG_W       = fcsg_pkg::CFG_W;

	// One span as it leaves the block.
	typedef struct packed {
		logic [9:0]  row;
		logic [9:0]  x_first;
		logic [9:0]  x_last;
		logic [15:0] color;
		logic        is_last;
	} span_t;

	logic             clk;
	logic             arst_n;
	logic [47:0]      s_axis_tdata;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [47:0]      m_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic             m_axis_tlast;
	logic             cfg_wr_en;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// Display size as the block should see it.
	logic [CFG_W-1:0] disp_width;
	logic [CFG_W-1:0] disp_height;

	// Spans still owed by the block, oldest first.
	span_t pending_spans[$];

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int circles_sent;
	int spans_checked;
	int config_writes;
	int cycle_count;

	filled_circle_span_generator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Highest legal coordinate for a display size: zero acts as one,
	// anything above 1024 acts as 1024.
	function automatic int coord_ceiling(input logic [CFG_W-1:0] size);
		int s;
		s = int'(size);
		if (s == 0) s = 1;
		if (s > 1024) s = 1024;
		return s - 1;
	endfunction

	function automatic int clip(input int v, input int ceiling);
		if (v < 0) return 0;
		if (v > ceiling) return ceiling;
		return v;
	endfunction

	// Build one span, clipping each end on its own.
	function automatic span_t make_span(input int sx, input int row, input int len,
			input logic [15:0] color);
		span_t s;
		int wl;
		int hl;
		wl = coord_ceiling(disp_width);
		hl = coord_ceiling(disp_height);
		s.row     = 10'(clip(row, hl));
		s.x_first = 10'(clip(sx, wl));
		s.x_last  = 10'(clip(sx + len - 1, wl));
		s.color   = color;
		s.is_last = 1'b0;
		return s;
	endfunction

	// Work out the spans of one circle and queue them in emission order:
	// center row, then per step the outer pair (only when the edge offset steps in
	// while still beyond the step limit) and the inner pair.
	function automatic void fill_circle_spans(input int cx, input int cy, input int r_in,
			input logic [15:0] color);
		span_t fresh[$];
		int r;
		int step_lim;
		int bound;
		int x;
		r = (r_in > TOP_RADIUS) ? TOP_RADIUS : r_in;
		// A zero radius yields nothing at all.
		if (r == 0) return;
		step_lim = r * 707 / 1000 + 1;
		bound    = r * r + r / 2;
		x        = r;
		fresh.push_back(make_span(cx - r, cy, 2 * r, color));
		for (int i = 1; i <= step_lim; i++) begin
			if (i * i + x * x > bound) begin
				if (x > step_lim && i > 1) begin
					fresh.push_back(make_span(cx - i + 1, cy + x, 2 * (i - 1), color));
					fresh.push_back(make_span(cx - i + 1, cy - x, 2 * (i - 1), color));
				end
				// Never take the edge offset below zero.
				if (x > 0) x--;
			end
			if (x > 0) begin
				fresh.push_back(make_span(cx - x, cy + i, 2 * x, color));
				fresh.push_back(make_span(cx - x, cy - i, 2 * x, color));
			end
		end
		fresh[fresh.size() - 1].is_last = 1'b1;
		foreach (fresh[k]) pending_spans.push_back(fresh[k]);
	endfunction

	// Offer one circle word and hold it until the block takes it.
	task automatic send_circle(input int cx, input int cy, input int r,
			input logic [15:0] color);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		// tdata: center_x, center_y, radius, fill_color from bit 0 up
		s_axis_tdata  = {7'd0, color, 5'(r), 10'(cy), 10'(cx)};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		fill_circle_spans(cx, cy, r, color);
		circles_sent++;
	endtask

	// Drop valid, let every owed span arrive, then give the block time to
	// finish anything that produces no span.
	task automatic drain_spans();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_spans.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_display(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == fcsg_pkg::REG_DISPLAY_WIDTH)
			disp_width = val;
		else
			disp_height = val;
		config_writes++;
	endtask

	// Mostly legal radii, small ones often, plus a few zero and oversized ones.
	function automatic int pick_radius();
		int n;
		n = $urandom_range(99);
		if (n < 3) return 0;
		if (n < 7) return $urandom_range(31, 20);
		if (n < 30) return $urandom_range(5, 1);
		return $urandom_range(TOP_RADIUS, 1);
	endfunction

	// Lean on both ends of the coordinate range so clipping gets exercised.
	function automatic int pick_coord();
		case ($urandom_range(3))
			0:       return $urandom_range(19);
			1:       return $urandom_range(1023, 1004);
			default: return $urandom_range(1023);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(4))
			0:       return CFG_W'($urandom_range(64, 1));
			1:       return CFG_W'($urandom_range(1024, 512));
			2:       return CFG_W'(1024);
			3:       return CFG_W'($urandom_range(2047, 1025));
			default: return CFG_W'($urandom_range(1024, 1));
		endcase
	endfunction

	// Reset sizes: centered, corner, clipped off both far edges, radius
	// corners, zero radius and oversized radius.
	task automatic test_default_display();
		send_circle(320, 240, 19, 16'hFFFF);
		send_circle(0, 0, 1, 16'h0000);
		send_circle(0, 0, 19, 16'h5A5A);
		send_circle(1023, 1023, 19, 16'hA5A5);
		send_circle(639, 479, 7, 16'h8001);
		send_circle(100, 100, 0, 16'h1234);
		send_circle(50, 60, 31, 16'h7FFE);
		send_circle(512, 300, 20, 16'hF800);
		send_circle(10, 470, 16, 16'h07E0);
		send_circle(630, 5, 8, 16'h001F);
		drain_spans();
	endtask

	// Zero, one-pixel, full and oversized displays.
	task automatic test_display_extremes();
		write_display(fcsg_pkg::REG_DISPLAY_WIDTH, '0);
		write_display(fcsg_pkg::REG_DISPLAY_HEIGHT, '0);
		send_circle(5, 5, 3, 16'hC3C3);
		send_circle(1023, 0, 19, 16'h3C3C);
		drain_spans();
		write_display(fcsg_pkg::REG_DISPLAY_WIDTH, CFG_W'(1));
		write_display(fcsg_pkg::REG_DISPLAY_HEIGHT, CFG_W'(1));
		send_circle(0, 0, 2, 16'hFFFF);
		send_circle(700, 900, 11, 16'h0F0F);
		drain_spans();
		write_display(fcsg_pkg::REG_DISPLAY_WIDTH, CFG_W'(1024));
		write_display(fcsg_pkg::REG_DISPLAY_HEIGHT, CFG_W'(1024));
		send_circle(1023, 1023, 19, 16'hF0F0);
		send_circle(1010, 12, 15, 16'h0001);
		drain_spans();
		write_display(fcsg_pkg::REG_DISPLAY_WIDTH, '1);
		write_display(fcsg_pkg::REG_DISPLAY_HEIGHT, '1);
		send_circle(1023, 1023, 19, 16'h8000);
		send_circle(0, 1023, 31, 16'hAAAA);
		send_circle(517, 3, 0, 16'h5555);
		drain_spans();
	endtask

	// One round of random circles under a given idle pattern and display.
	task automatic test_random_circles(input int count, input int sidle, input int ridle);
		send_idle_pct  = sidle;
		recv_stall_pct = ridle;
		write_display(fcsg_pkg::REG_DISPLAY_WIDTH, pick_size());
		write_display(fcsg_pkg::REG_DISPLAY_HEIGHT, pick_size());
		for (int n = 0; n < count; n++)
			send_circle(pick_coord(), pick_coord(), pick_radius(), 16'($urandom));
		drain_spans();
	endtask

	// Randomly hold off the span side; sample-stable since it moves on the
	// falling edge.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare every span word taken against the oldest owed span.
	always @(posedge clk) begin : span_check
		span_t want;
		span_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			// tdata: span_row, span_x_first, span_x_last, span_color from bit 0 up
			got.row     = m_axis_tdata[9:0];
			got.x_first = m_axis_tdata[19:10];
			got.x_last  = m_axis_tdata[29:20];
			got.color   = m_axis_tdata[45:30];
			got.is_last = m_axis_tlast;
			if (pending_spans.size() == 0) begin
				error_count++;
				$display("%0t: span with none owed: row %0d x %0d..%0d color %h last %b",
					$time, got.row, got.x_first, got.x_last, got.color, got.is_last);
			end else begin
				want = pending_spans.pop_front();
				spans_checked++;
				if (got != want) begin
					error_count++;
					$display("%0t: span mismatch: expected row %0d x %0d..%0d color %h last %b",
						$time, want.row, want.x_first, want.x_last, want.color,
						want.is_last);
					$display("%0t:                actual   row %0d x %0d..%0d color %h last %b",
						$time, got.row, got.x_first, got.x_last, got.color, got.is_last);
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_filled_circle_span_generator_core: errors");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tvalid  = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = fcsg_pkg::REG_DISPLAY_WIDTH;
		cfg_data       = '0;
		disp_width     = fcsg_pkg::DISPLAY_WIDTH_RST;
		disp_height    = fcsg_pkg::DISPLAY_HEIGHT_RST;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		circles_sent   = 0;
		config_writes  = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_default_display();
		test_display_extremes();
		// Sender mostly busy and span side often stalled, then swap, then free run.
		test_random_circles(117, 7, 68);
		test_random_circles(117, 68, 7);
		test_random_circles(117, 0, 0);

		$display("covered %0d circles and %0d span words over %0d display writes",
			circles_sent, spans_checked, config_writes);
		$display("including zero/oversized radius and zero/oversized display sizes");
		if (error_count == 0)
			$display("tb_filled_circle_span_generator_core: clean");
		else
			$display("tb_filled_circle_span_generator_core: errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/fcsg_pkg.sv
sv/filled_circle_span_generator_core.sv
sv/fcsg_checker.sv
dv/tb_filled_circle_span_generator_core.sv
